// ----- src/bdc_pkg.sv -----
package bdc_pkg;

  // Event codes as they appear on the event_kind output.
  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_CLICK   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } bdc_kind_t;

  // Number of distinct event kinds one button can raise.
  localparam int NUM_KINDS = 5;

  // At most this many events are reported for one tick; the rest are dropped.
  localparam int MAX_EVENTS = 4;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLICK_GAP  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 2'd1;

  // Register reset values.
  localparam logic [15:0] CLICK_GAP_RESET  = 16'd100;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd256;

  // Debounce history patterns.
  localparam logic [7:0] HIST_RESET   = 8'h02;
  localparam logic [7:0] HIST_PRESS   = 8'h7f;
  localparam logic [7:0] HIST_RELEASE = 8'h80;

  // Saturation value of the held and idle counters.
  localparam logic [15:0] COUNT_MAX = 16'hffff;

  // Events raised by one button on one tick.
  typedef struct packed {
    logic repeat_ev;
    logic long_ev;
    logic click_ev;
    logic release_ev;
    logic press_ev;
  } bdc_flags_t;

endpackage

// ----- src/bdc_button.sv -----
module bdc_button #(
  parameter int REPEAT_PERIOD = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                level,
  input  logic [15:0]         click_gap,
  input  logic [15:0]         long_press,
  output bdc_pkg::bdc_flags_t flags,
  output logic [7:0]          click_num
);

  localparam int PW = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(REPEAT_PERIOD - 1);

  logic [7:0]    history;
  logic          is_pressed;
  logic          is_released;
  logic [15:0]   held;
  logic [15:0]   idle;
  logic [PW-1:0] phase;
  logic [7:0]    clicks;

  logic [7:0]    history_next;
  logic          is_pressed_next;
  logic          is_released_next;
  logic [15:0]   held_next;
  logic [15:0]   idle_next;
  logic [PW-1:0] phase_next;
  logic [7:0]    clicks_next;

  logic [15:0]   held_inc;
  logic [15:0]   idle_inc;
  logic [PW-1:0] phase_inc;
  logic [7:0]    clicks_mid;
  logic          hit_press;
  logic          hit_release;

  // Counters advance before the new sample is looked at. The phase tracks
  // the held count modulo the repeat period so no divider is needed.
  always_comb begin
    held_inc  = held;
    phase_inc = phase;
    idle_inc  = idle;
    if (is_pressed && (held != bdc_pkg::COUNT_MAX)) begin
      held_inc  = held + 16'd1;
      phase_inc = (phase == PHASE_LAST) ? '0 : phase + PW'(1);
    end
    if (is_released && (idle != bdc_pkg::COUNT_MAX)) begin
      idle_inc = idle + 16'd1;
    end
  end

  assign history_next = {history[6:0], level};
  assign hit_press    = (history_next == bdc_pkg::HIST_PRESS);
  assign hit_release  = (history_next == bdc_pkg::HIST_RELEASE);

  // A hold longer than the gap ends the click sequence at release.
  assign clicks_mid = (held_inc > click_gap) ? 8'd0 : clicks;

  // State update and event detection for this tick.
  always_comb begin
    is_pressed_next  = is_pressed;
    is_released_next = is_released;
    held_next        = held_inc;
    idle_next        = idle_inc;
    phase_next       = phase_inc;
    clicks_next      = clicks;
    flags            = '0;
    click_num        = 8'd0;
    if (hit_press) begin
      if (idle_inc > click_gap) begin
        clicks_next = 8'd1;
      end
      is_pressed_next  = 1'b1;
      is_released_next = 1'b0;
      held_next        = 16'd0;
      phase_next       = '0;
      flags.press_ev   = 1'b1;
    end
    if (hit_release) begin
      is_released_next = 1'b1;
      is_pressed_next  = 1'b0;
      idle_next        = 16'd0;
      flags.release_ev = 1'b1;
      flags.click_ev   = (clicks_mid != 8'd0);
      click_num        = clicks_mid;
      clicks_next      = clicks_mid + 8'd1;
    end
    // Long press and repeat are only reported while the button is down.
    flags.long_ev   = is_pressed_next && (held_next == long_press);
    flags.repeat_ev = is_pressed_next && (held_next > long_press) && (phase_next == '0);
  end

  // Per-button state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      history     <= bdc_pkg::HIST_RESET;
      is_pressed  <= 1'b0;
      is_released <= 1'b0;
      held        <= 16'd0;
      idle        <= 16'd0;
      phase       <= '0;
      clicks      <= 8'd0;
    end else if (tick) begin
      history     <= history_next;
      is_pressed  <= is_pressed_next;
      is_released <= is_released_next;
      held        <= held_next;
      idle        <= idle_next;
      phase       <= phase_next;
      clicks      <= clicks_next;
    end
  end

  // A button is never pressed and released at the same time.
  a_press_release_excl: assert property (@(posedge clk) disable iff (rst)
    !(is_pressed && is_released))
    else $error("button both pressed and released");

  // The repeat phase follows the held count while it is below the period.
  a_phase_tracks_held: assert property (@(posedge clk) disable iff (rst)
    (held < 16'(REPEAT_PERIOD)) |-> (phase == PW'(held)))
    else $error("repeat phase lost track of held count");

endmodule

// ----- src/bdc_emit.sv -----
module bdc_emit #(
  parameter int NUM_BUTTONS = 2,
  parameter int BID_W       = 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_fire,
  input  logic [NUM_BUTTONS*bdc_pkg::NUM_KINDS-1:0] in_mask,
  input  logic [7:0]                           in_clicks [NUM_BUTTONS],
  output logic                                 take_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [BID_W-1:0]                     button_id,
  output logic [2:0]                           event_kind,
  output logic [7:0]                           click_number,
  output logic                                 last_event
);

  localparam int MW = NUM_BUTTONS * bdc_pkg::NUM_KINDS;
  localparam int CW = $clog2(bdc_pkg::MAX_EVENTS);
  localparam logic [CW-1:0] CNT_LAST = CW'(bdc_pkg::MAX_EVENTS - 1);

  logic [MW-1:0]     pend;
  logic [CW-1:0]     cnt;
  logic [7:0]        clicks [NUM_BUTTONS];

  logic              load;
  logic              any;
  logic [MW-1:0]     rest;
  logic [BID_W-1:0]  sel_b;
  bdc_pkg::bdc_kind_t sel_k;
  logic              last_pick;
  logic [7:0]        sel_click;

  // The output register can take a new event when empty or being drained.
  assign load = !out_valid || out_ready;

  // Pick the pending event that comes first: button order, then kind order.
  always_comb begin
    any   = 1'b0;
    rest  = pend;
    sel_b = '0;
    sel_k = bdc_pkg::EV_PRESS;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      for (int k = 0; k < bdc_pkg::NUM_KINDS; k++) begin
        if (!any && pend[b*bdc_pkg::NUM_KINDS + k]) begin
          any   = 1'b1;
          sel_b = BID_W'(b);
          sel_k = bdc_pkg::bdc_kind_t'(3'(k));
          rest[b*bdc_pkg::NUM_KINDS + k] = 1'b0;
        end
      end
    end
  end

  // The fourth event of a tick is the last; later ones are dropped.
  assign last_pick = (rest == '0) || (cnt == CNT_LAST);
  assign sel_click = (sel_k == bdc_pkg::EV_CLICK) ? clicks[sel_b] : 8'd0;

  // A new tick is taken once the events of the previous one are all loaded.
  assign take_ready = !any || (load && last_pick);

  // Control state of the serializer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= '0;
      cnt       <= '0;
    end else begin
      if (load) begin
        out_valid <= any;
        if (any) begin
          pend <= last_pick ? '0 : rest;
          cnt  <= cnt + CW'(1);
        end
      end
      if (in_fire) begin
        pend <= in_mask;
        cnt  <= '0;
      end
    end
  end

  // Result payload and captured click counts.
  always_ff @(posedge clk) begin
    if (load && any) begin
      button_id    <= sel_b;
      event_kind   <= sel_k;
      click_number <= sel_click;
      last_event   <= last_pick;
    end
    if (in_fire) begin
      clicks <= in_clicks;
    end
  end

  // Loading the last event of a tick leaves nothing pending unless a new
  // tick is captured at the same edge.
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (load && any && last_pick && !in_fire) |=> (pend == '0))
    else $error("events left pending after last event");

  // Click events carry a nonzero count; every other event carries zero.
  a_click_number: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == 3'(bdc_pkg::EV_CLICK)) == (click_number != 8'd0)))
    else $error("click number does not match event kind");

  // A new tick is never captured over events still waiting to be loaded.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (!any || (load && last_pick)))
    else $error("tick captured over pending events");

endmodule

// ----- src/button_debounce_click_longpress.sv -----
// Debounces NUM_BUTTONS button levels, one tick per input transaction, and
// reports press, release, multi-click, long press and long-press repeat
// events as output transactions, at most four per tick, in button order and
// within a button in the order press, release, click, long press, repeat;
// last_event marks the final event of a tick. A tick is processed in the
// cycle it is accepted; its events then leave through a single output
// register at one per cycle while out_ready is high, and the next tick is
// accepted in the same cycle that the previous tick's last event is loaded.
// A tick with no events produces no output transaction. Configuration
// writes take effect at once and should only be made while no events are
// pending.
module button_debounce_click_longpress #(
  parameter int NUM_BUTTONS   = 2,
  parameter int REPEAT_PERIOD = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [NUM_BUTTONS-1:0]          button_levels,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [((NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1)-1:0] button_id,
  output logic [2:0]                      event_kind,
  output logic [7:0]                      click_number,
  output logic                            last_event
);

  localparam int BID_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int MW    = NUM_BUTTONS * bdc_pkg::NUM_KINDS;

  logic [15:0]         click_gap_ticks;
  logic [15:0]         long_press_ticks;
  logic                tick;
  bdc_pkg::bdc_flags_t flags [NUM_BUTTONS];
  logic [7:0]          click_num [NUM_BUTTONS];
  logic [MW-1:0]       mask;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      click_gap_ticks  <= bdc_pkg::CLICK_GAP_RESET;
      long_press_ticks <= bdc_pkg::LONG_PRESS_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == bdc_pkg::CFG_CLICK_GAP) begin
        click_gap_ticks <= cfg_data;
      end
      if (cfg_index == bdc_pkg::CFG_LONG_PRESS) begin
        long_press_ticks <= cfg_data;
      end
    end
  end

  assign tick = in_valid && in_ready;

  // One debounce and click tracker per button.
  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    bdc_button #(
      .REPEAT_PERIOD(REPEAT_PERIOD)
    ) u_button (
      .clk       (clk),
      .rst       (rst),
      .tick      (tick),
      .level     (button_levels[b]),
      .click_gap (click_gap_ticks),
      .long_press(long_press_ticks),
      .flags     (flags[b]),
      .click_num (click_num[b])
    );
    assign mask[b*bdc_pkg::NUM_KINDS +: bdc_pkg::NUM_KINDS] = flags[b];
  end

  // Event serializer and output register.
  bdc_emit #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .BID_W      (BID_W)
  ) u_emit (
    .clk         (clk),
    .rst         (rst),
    .in_fire     (tick),
    .in_mask     (mask),
    .in_clicks   (click_num),
    .take_ready  (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .button_id   (button_id),
    .event_kind  (event_kind),
    .click_number(click_number),
    .last_event  (last_event)
  );

  // Output handshake: a presented event holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(event_kind) && $stable(button_id)))
    else $error("output event changed while stalled");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int NB = 2;
  localparam int REPEAT_TICKS = 128;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Register indexes that select no register; writes to them must be ignored.
  localparam logic [bdc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [bdc_pkg::CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct {
    logic                bid;
    bdc_pkg::bdc_kind_t  kind;
    logic [7:0]          clicks;
    logic                last_ev;
  } btn_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [bdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [NB-1:0] button_levels = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic button_id;
  logic [2:0] event_kind;
  logic [7:0] click_number;
  logic last_event;

  button_debounce_click_longpress #(
    .NUM_BUTTONS  (NB),
    .REPEAT_PERIOD(REPEAT_TICKS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_levels(button_levels),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .button_id    (button_id),
    .event_kind   (event_kind),
    .click_number (click_number),
    .last_event   (last_event)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted button state and register copies.
  logic [7:0]  hist_q     [NB];
  logic        pressed_q  [NB];
  logic        released_q [NB];
  logic [15:0] held_q     [NB];
  logic [15:0] idle_q     [NB];
  logic [7:0]  clicks_q   [NB];
  logic [15:0] gap_cfg;
  logic [15:0] long_cfg;

  btn_event_t    events_due[$];
  logic [NB-1:0] levels_pending[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  // Run-length state of the random level generator, one run per button.
  int unsigned run_left [NB];
  logic        run_level[NB];

  task automatic reset_model();
    gap_cfg = bdc_pkg::CLICK_GAP_RESET;
    long_cfg = bdc_pkg::LONG_PRESS_RESET;
    for (int b = 0; b < NB; b++) begin
      hist_q[b] = bdc_pkg::HIST_RESET;
      pressed_q[b] = 1'b0;
      released_q[b] = 1'b0;
      held_q[b] = '0;
      idle_q[b] = '0;
      clicks_q[b] = '0;
      run_left[b] = 0;
      run_level[b] = 1'b0;
    end
  endtask

  // Queue one expected event unless the tick has already reached its event limit.
  task automatic post_event(inout int n, input int b, input bdc_pkg::bdc_kind_t kind,
                            input logic [7:0] clicks);
    btn_event_t ev;
    if (n >= bdc_pkg::MAX_EVENTS) return;
    ev.bid = b[0];
    ev.kind = kind;
    ev.clicks = clicks;
    ev.last_ev = 1'b0;
    events_due.push_back(ev);
    n++;
  endtask

  // Advance the predicted debounce state by one tick and queue its events.
  task automatic debounce_tick(input logic [NB-1:0] levels);
    int n;
    logic [7:0] h;
    n = 0;
    for (int b = 0; b < NB; b++) begin
      if (pressed_q[b] && held_q[b] != bdc_pkg::COUNT_MAX) held_q[b] = held_q[b] + 16'd1;
      if (released_q[b] && idle_q[b] != bdc_pkg::COUNT_MAX) idle_q[b] = idle_q[b] + 16'd1;
      h = {hist_q[b][6:0], levels[b]};
      hist_q[b] = h;
      if (h == bdc_pkg::HIST_PRESS) begin
        if (idle_q[b] > gap_cfg) clicks_q[b] = 8'd1;
        pressed_q[b] = 1'b1;
        released_q[b] = 1'b0;
        held_q[b] = '0;
        post_event(n, b, bdc_pkg::EV_PRESS, 8'd0);
      end
      if (h == bdc_pkg::HIST_RELEASE) begin
        if (held_q[b] > gap_cfg) clicks_q[b] = 8'd0;
        released_q[b] = 1'b1;
        pressed_q[b] = 1'b0;
        idle_q[b] = '0;
        post_event(n, b, bdc_pkg::EV_RELEASE, 8'd0);
        if (clicks_q[b] != 8'd0) post_event(n, b, bdc_pkg::EV_CLICK, clicks_q[b]);
        clicks_q[b] = clicks_q[b] + 8'd1;
      end
      // Long press and repeat are only reported while the button is held.
      if (pressed_q[b]) begin
        if (held_q[b] == long_cfg) post_event(n, b, bdc_pkg::EV_LONG, 8'd0);
        if (held_q[b] > long_cfg && (held_q[b] % REPEAT_TICKS) == 0)
          post_event(n, b, bdc_pkg::EV_REPEAT, 8'd0);
      end
    end
    if (n > 0) events_due[events_due.size()-1].last_ev = 1'b1;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Level run lengths: mostly long enough to debounce, some bounces, a few long holds.
  function automatic int unsigned pick_run(input logic lvl);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return $urandom_range(1, 6);
    if (r < 85) return $urandom_range(7, 30);
    if (lvl) return $urandom_range(31, 140);
    return $urandom_range(31, 120);
  endfunction

  task automatic queue_const(input logic [NB-1:0] lv, input int n);
    repeat (n) levels_pending.push_back(lv);
  endtask

  // Well-formed press and release runs per button, with some random noise ticks.
  task automatic queue_random(input int n);
    logic [NB-1:0] tick;
    repeat (n) begin
      for (int b = 0; b < NB; b++) begin
        if (run_left[b] == 0) begin
          run_level[b] = ~run_level[b];
          run_left[b] = pick_run(run_level[b]);
        end
        run_left[b]--;
        tick[b] = run_level[b];
      end
      if ($urandom_range(19) == 0) tick = NB'($urandom_range(3));
      levels_pending.push_back(tick);
    end
  endtask

  // Wait until every tick is accepted and every event has arrived, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (levels_pending.size() != 0 || in_valid || events_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bdc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == bdc_pkg::CFG_CLICK_GAP) gap_cfg = val;
    else if (idx == bdc_pkg::CFG_LONG_PRESS) long_cfg = val;
  endtask

  task automatic finish_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Tick driver: predicts each accepted transaction and launches the next pending one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && !in_ready)) begin
      if (in_valid) debounce_tick(button_levels);
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (levels_pending.size() != 0) begin
        in_valid <= 1'b1;
        button_levels <= levels_pending.pop_front();
        send_gap <= idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Event receiver with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(3) == 0) stall_left <= idle_len();
    end
  end

  // Compare each event transaction with the oldest predicted event.
  always @(posedge clk) begin : event_check
    btn_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        $error("unexpected event: button_id %0d event_kind %0d", button_id, event_kind);
        err_count++;
      end else begin
        want = events_due.pop_front();
        if (button_id !== want.bid) begin
          $error("button_id expected %0d actual %0d", want.bid, button_id);
          err_count++;
        end
        if (event_kind !== want.kind) begin
          $error("event_kind expected %0d actual %0d", want.kind, event_kind);
          err_count++;
        end
        if (click_number !== want.clicks) begin
          $error("click_number expected %0d actual %0d", want.clicks, click_number);
          err_count++;
        end
        if (last_event !== want.last_ev) begin
          $error("last_event expected %0d actual %0d", want.last_ev, last_event);
          err_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings. Zeros from the reset history release both buttons without
    // a click, then a joint press and release fills a tick with four events.
    queue_const(2'b00, 6);
    queue_const(2'b11, 7);
    queue_const(2'b00, 7);
    queue_const(2'b01, 7);
    queue_const(2'b00, 7);
    queue_random(50);
    wait_drained();

    // Zero gap and zero long press: the long press comes on the press tick.
    write_reg(bdc_pkg::CFG_CLICK_GAP, 16'd0);
    write_reg(bdc_pkg::CFG_LONG_PRESS, 16'd0);
    write_reg(CFG_SPARE_2, 16'hffff);
    write_reg(CFG_SPARE_3, 16'h0001);
    finish_writes();
    queue_const(2'b00, 8);
    queue_const(2'b11, 7);
    queue_const(2'b00, 7);
    queue_random(30);
    wait_drained();

    // Short long press with a hold long enough for one repeat.
    write_reg(bdc_pkg::CFG_CLICK_GAP, 16'd10);
    write_reg(bdc_pkg::CFG_LONG_PRESS, 16'd5);
    finish_writes();
    queue_const(2'b00, 8);
    queue_const(2'b01, 136);
    queue_const(2'b00, 8);
    wait_drained();

    // Random settings, with a stretch of back-to-back transactions.
    write_reg(bdc_pkg::CFG_CLICK_GAP, 16'($urandom_range(3, 30)));
    write_reg(bdc_pkg::CFG_LONG_PRESS, 16'($urandom_range(1, 40)));
    finish_writes();
    no_idle = 1'b1;
    queue_random(40);
    wait_drained();

    // Maximum settings: no long press within a short hold and no idle restart.
    write_reg(bdc_pkg::CFG_CLICK_GAP, 16'hffff);
    write_reg(bdc_pkg::CFG_LONG_PRESS, 16'hffff);
    finish_writes();
    no_idle = 1'b0;
    queue_const(2'b00, 8);
    repeat (2) begin
      queue_const(2'b10, 7);
      queue_const(2'b00, 7);
    end
    wait_drained();

    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
